FILE: src/jofe_pkg.sv
// shared types, character codes and constants of the offset field extractor
`timescale 1ns / 1ps
`default_nettype none

package jofe_pkg;

   localparam int MAG_W = 17;
   localparam int SEC_W = 18;
   localparam logic [MAG_W-1:0] MAG_BOUND = 17'h1FFFF;
   localparam logic signed [SEC_W-1:0] QUARTER_SEC = 18'sd900;
   localparam logic [SEC_W-1:0] HALF_QUARTER_SEC = 18'd450;
   // floor(x / 900) == (x * RECIP_900) >> RECIP_SHIFT for every x below 2**18
   localparam logic [SEC_W-1:0] RECIP_900 = 18'd149131;
   localparam int RECIP_SHIFT = 27;

   localparam logic signed [SEC_W-1:0] MIN_SEC_RESET = -18'sd43200;
   localparam logic signed [SEC_W-1:0] MAX_SEC_RESET = 18'sd50400;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam int FAIL_LEN = 6;
   localparam int KEY_LEN = 8;
   localparam logic [7:0] FAIL_WORD [0:FAIL_LEN-1] = '{8'h22, 8'h66, 8'h61, 8'h69, 8'h6C, 8'h22};
   localparam logic [7:0] KEY_WORD [0:KEY_LEN-1] =
      '{8'h22, 8'h6F, 8'h66, 8'h66, 8'h73, 8'h65, 8'h74, 8'h22};

   localparam logic CSR_MIN_QUARTERS = 1'b0;
   localparam logic CSR_MAX_QUARTERS = 1'b1;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_COLON,
      PH_AFTER_COLON,
      PH_SIGN,
      PH_DIGITS,
      PH_GOOD,
      PH_BAD
   } phase_type;

   // what the scanner hands over at end of text
   typedef struct packed {
      logic             good;
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } snap_type;

   function automatic logic [2:0] fail_advance(input logic [2:0] pos, input logic [7:0] c);
      logic [2:0] nxt;
      if (pos < 3'(FAIL_LEN) && FAIL_WORD[pos] == c) begin
         nxt = pos + 3'd1;
      end else begin
         nxt = (c == CH_QUOTE) ? 3'd1 : 3'd0;
      end
      return nxt;
   endfunction

   function automatic logic [3:0] key_advance(input logic [3:0] pos, input logic [7:0] c);
      logic [3:0] nxt;
      if (!pos[3] && KEY_WORD[pos[2:0]] == c) begin
         nxt = pos + 4'd1;
      end else begin
         nxt = (c == CH_QUOTE) ? 4'd1 : 4'd0;
      end
      return nxt;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_term(input logic [7:0] c);
      return c == CH_COMMA || c == CH_RBRACE || c == CH_SPACE || c == CH_CR ||
             c == CH_LF || c == CH_TAB;
   endfunction

endpackage

`default_nettype wire

FILE: src/jofe_scan.sv
// per-character matchers and offset number parser
`timescale 1ns / 1ps
`default_nettype none

module jofe_scan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              char_take,
   input  wire logic              end_take,
   input  wire logic [7:0]        char_code,
   output jofe_pkg::snap_type     snap
);

   logic [2:0]                 fail_pos_ff, fail_pos_in;
   logic                       fail_seen_ff, fail_seen_in;
   logic [3:0]                 key_pos_ff, key_pos_in;
   jofe_pkg::phase_type        phase_ff, phase_in;
   logic                       negative_ff, negative_in;
   logic [jofe_pkg::MAG_W-1:0] mag_ff, mag_in;

   logic [2:0]                 fail_adv;
   logic [3:0]                 key_adv;
   logic [jofe_pkg::MAG_W+3:0] mag_sum;
   logic [jofe_pkg::MAG_W-1:0] mag_digit;

   assign fail_adv = jofe_pkg::fail_advance(fail_pos_ff, char_code);
   assign key_adv  = jofe_pkg::key_advance(key_pos_ff, char_code);

   // magnitude * 10 + digit, saturating
   assign mag_sum = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0}
                  + {17'd0, char_code[3:0] - 4'(jofe_pkg::CH_ZERO)};
   assign mag_digit = (mag_sum > {4'd0, jofe_pkg::MAG_BOUND}) ? jofe_pkg::MAG_BOUND
                                                               : mag_sum[jofe_pkg::MAG_W-1:0];

   always_comb begin
      fail_pos_in  = fail_pos_ff;
      fail_seen_in = fail_seen_ff;
      key_pos_in   = key_pos_ff;
      phase_in     = phase_ff;
      negative_in  = negative_ff;
      mag_in       = mag_ff;
      if (end_take) begin
         fail_pos_in  = 3'd0;
         fail_seen_in = 1'b0;
         key_pos_in   = 4'd0;
         phase_in     = jofe_pkg::PH_KEY;
         negative_in  = 1'b0;
         mag_in       = '0;
      end else if (char_take) begin
         if (!fail_seen_ff) begin
            if (fail_adv == 3'(jofe_pkg::FAIL_LEN)) begin
               fail_seen_in = 1'b1;
               fail_pos_in  = 3'd0;
            end else begin
               fail_pos_in = fail_adv;
            end
         end
         case (phase_ff)
            jofe_pkg::PH_KEY: begin
               if (key_adv == 4'(jofe_pkg::KEY_LEN)) begin
                  key_pos_in = 4'd0;
                  phase_in   = jofe_pkg::PH_COLON;
               end else begin
                  key_pos_in = key_adv;
               end
            end
            jofe_pkg::PH_COLON: begin
               if (char_code == jofe_pkg::CH_COLON) begin
                  phase_in = jofe_pkg::PH_AFTER_COLON;
               end else if (!jofe_pkg::is_blank(char_code)) begin
                  phase_in = jofe_pkg::PH_BAD;
               end
            end
            jofe_pkg::PH_AFTER_COLON: begin
               if (jofe_pkg::is_blank(char_code)) begin
                  phase_in = jofe_pkg::PH_AFTER_COLON;
               end else if (char_code == jofe_pkg::CH_MINUS ||
                            char_code == jofe_pkg::CH_PLUS) begin
                  negative_in = (char_code == jofe_pkg::CH_MINUS);
                  phase_in    = jofe_pkg::PH_SIGN;
               end else if (jofe_pkg::is_digit(char_code)) begin
                  mag_in   = mag_digit;
                  phase_in = jofe_pkg::PH_DIGITS;
               end else begin
                  phase_in = jofe_pkg::PH_BAD;
               end
            end
            jofe_pkg::PH_SIGN: begin
               if (jofe_pkg::is_digit(char_code)) begin
                  mag_in   = mag_digit;
                  phase_in = jofe_pkg::PH_DIGITS;
               end else begin
                  phase_in = jofe_pkg::PH_BAD;
               end
            end
            jofe_pkg::PH_DIGITS: begin
               if (jofe_pkg::is_digit(char_code)) begin
                  mag_in = mag_digit;
               end else if (jofe_pkg::is_term(char_code)) begin
                  phase_in = jofe_pkg::PH_GOOD;
               end else begin
                  phase_in = jofe_pkg::PH_BAD;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_pos_ff  <= 3'd0;
         fail_seen_ff <= 1'b0;
         key_pos_ff   <= 4'd0;
         phase_ff     <= jofe_pkg::PH_KEY;
         negative_ff  <= 1'b0;
         mag_ff       <= '0;
      end else begin
         fail_pos_ff  <= fail_pos_in;
         fail_seen_ff <= fail_seen_in;
         key_pos_ff   <= key_pos_in;
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         mag_ff       <= mag_in;
      end
   end

   assign snap.good      = !fail_seen_ff && phase_ff == jofe_pkg::PH_GOOD;
   assign snap.negative  = negative_ff;
   assign snap.magnitude = mag_ff;

endmodule

`default_nettype wire

FILE: src/json_offset_field_extractor.sv
// top level of the offset field extractor: handshake, limits, evaluation and result register
//
// Input stream (req_): one transfer per text character, tuser = 0 and the byte in
// tdata; a transfer with tuser = 1 marks end of text, its tdata is ignored.
// Result stream (rsp_): exactly one transfer per end-of-text transfer, carrying a
// valid flag and the offset rounded to quarter hours (0 when not valid).
// Configuration: csr_we writes csr_wdata to register csr_addr (0 = minimum quarters,
// signed 8 bit; 1 = maximum quarters, 7 bit); limits are scaled to seconds on write.
// Throughput: one character or end marker per cycle while req_tready is high.
// Characters update the matcher state in the cycle they are taken. An end marker
// snapshots the parse state into an evaluation register; from there the range check
// and the divide by 900 (one reciprocal multiply) go into the result register once
// it is free. Reset clears the parser and the valid flags of the evaluation and result
// registers and restores the default limits. When the receiver stalls, the result waits
// in its register while one more end marker may be taken into the evaluation register;
// req_tready then drops until the result transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module json_offset_field_extractor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_code
   input  wire logic        req_tuser,   // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // valid_res, quarter_hours[8:1], zeros
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   localparam int SW = jofe_pkg::SEC_W;

   logic                         req_xfer, char_take, end_take, out_free;
   jofe_pkg::snap_type           snap;

   logic signed [SW-1:0]         min_sec_ff, min_sec_in;
   logic signed [SW-1:0]         max_sec_ff, max_sec_in;

   logic                         s1_valid_ff, s1_valid_in;
   jofe_pkg::snap_type           s1_snap_ff;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_ok_ff;
   logic [7:0]                   out_q_ff;

   logic signed [SW-1:0]         sec;
   logic [SW-1:0]                mag_half;
   logic [2*SW-1:0]              quot_prod;
   logic [7:0]                   rounded;
   logic                         in_range;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign char_take  = req_xfer && !req_tuser;
   assign end_take   = req_xfer && req_tuser;

   jofe_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .char_take (char_take),
      .end_take  (end_take),
      .char_code (req_tdata),
      .snap      (snap)
   );

   // limits kept in seconds
   always_comb begin
      min_sec_in = min_sec_ff;
      max_sec_in = max_sec_ff;
      if (csr_we) begin
         case (csr_addr)
            jofe_pkg::CSR_MIN_QUARTERS: begin
               min_sec_in = SW'(SW'(signed'(csr_wdata)) * jofe_pkg::QUARTER_SEC);
            end
            jofe_pkg::CSR_MAX_QUARTERS: begin
               max_sec_in = SW'(signed'({11'd0, csr_wdata[6:0]}) * jofe_pkg::QUARTER_SEC);
            end
            default: begin
               min_sec_in = min_sec_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sec_ff <= jofe_pkg::MIN_SEC_RESET;
         max_sec_ff <= jofe_pkg::MAX_SEC_RESET;
      end else begin
         min_sec_ff <= min_sec_in;
         max_sec_ff <= max_sec_in;
      end
   end

   // evaluation register
   assign s1_valid_in = end_take || (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_take) begin
         s1_snap_ff <= snap;
      end
   end

   // range check in seconds, then round to nearest quarter hour
   assign sec = s1_snap_ff.negative ? -signed'({1'b0, s1_snap_ff.magnitude})
                                    : signed'({1'b0, s1_snap_ff.magnitude});
   assign in_range = s1_snap_ff.good && s1_snap_ff.magnitude < jofe_pkg::MAG_BOUND &&
                     sec >= min_sec_ff && sec <= max_sec_ff;
   assign mag_half  = {1'b0, s1_snap_ff.magnitude} + jofe_pkg::HALF_QUARTER_SEC;
   assign quot_prod = mag_half * jofe_pkg::RECIP_900;
   assign rounded   = quot_prod[jofe_pkg::RECIP_SHIFT+7:jofe_pkg::RECIP_SHIFT];

   // result register
   assign out_valid_in = s1_valid_ff || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ok_ff <= in_range;
         out_q_ff  <= !in_range ? 8'd0 : (s1_snap_ff.negative ? -rounded : rounded);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_q_ff, out_ok_ff};

endmodule

`default_nettype wire

FILE: src/jofe_checker.sv
// port-level checks of the offset field extractor and their binding
`timescale 1ns / 1ps
`default_nettype none

module jofe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // a result never stays pending after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a fresh result comes only after an end-of-text transfer, via the evaluation register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser, 2))
      else $error("result without end-of-text transfer");

   // input only backs up while the result side is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");

   // rejected offsets read as zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'd0)
      else $error("invalid result with nonzero offset");

endmodule

bind json_offset_field_extractor jofe_checker u_jofe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: sim/offset_result_checker.sv
// stream monitor that predicts and compares the offset extractor's results
`timescale 1ns / 1ps

module offset_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code
   input  logic        req_tuser,   // kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // valid_res, quarter_hours[8:1], zeros
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata,
   output int          mismatch_count,
   output int          pending_count,
   output int          compared_count
);

   localparam int SEC_PER_QUARTER = 900;
   localparam int HALF_QUARTER = 450;
   localparam int MAG_CEIL = 131071;

   typedef struct packed {
      logic              ok;
      logic signed [7:0] quarters;
   } offset_result_type;

   offset_result_type expected_offsets[$];

   string fail_pat = "\"fail\"";
   string key_pat = "\"offset\"";

   logic signed [7:0] lim_min;
   logic [6:0]        lim_max;

   logic [2:0]          fail_pos;
   logic                fail_hit;
   logic [3:0]          key_pos;
   jofe_pkg::phase_type phase;
   logic                minus;
   logic [16:0]         mag;

   int mismatches;
   int compared;

   // on a miss the only border of either word is the opening quote
   function automatic int match_step(input string pat, input int pos, input logic [7:0] c);
      if (pos < pat.len() && pat[pos] == c) begin
         return pos + 1;
      end
      return (c == "\"") ? 1 : 0;
   endfunction

   function automatic logic is_gap(input logic [7:0] c);
      return c == " " || c == "\t";
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic ends_number(input logic [7:0] c);
      return c == "," || c == "}" || c == " " || c == "\r" || c == "\n" || c == "\t";
   endfunction

   task automatic clear_parse();
      fail_pos = '0;
      fail_hit = 1'b0;
      key_pos = '0;
      phase = jofe_pkg::PH_KEY;
      minus = 1'b0;
      mag = '0;
   endtask

   task automatic add_numeral(input logic [7:0] c);
      int v;
      v = int'(mag) * 10 + int'(c) - 48;
      mag = (v > MAG_CEIL) ? 17'(MAG_CEIL) : 17'(v);
   endtask

   task automatic scan_char(input logic [7:0] c);
      if (!fail_hit) begin
         fail_pos = 3'(match_step(fail_pat, int'(fail_pos), c));
         if (fail_pos == 3'd6) begin
            fail_hit = 1'b1;
            fail_pos = '0;
         end
      end
      case (phase)
         jofe_pkg::PH_KEY: begin
            key_pos = 4'(match_step(key_pat, int'(key_pos), c));
            if (key_pos == 4'd8) begin
               key_pos = '0;
               phase = jofe_pkg::PH_COLON;
            end
         end
         jofe_pkg::PH_COLON: begin
            if (c == ":") phase = jofe_pkg::PH_AFTER_COLON;
            else if (!is_gap(c)) phase = jofe_pkg::PH_BAD;
         end
         jofe_pkg::PH_AFTER_COLON: begin
            if (c == "-" || c == "+") begin
               minus = (c == "-");
               phase = jofe_pkg::PH_SIGN;
            end else if (is_numeral(c)) begin
               add_numeral(c);
               phase = jofe_pkg::PH_DIGITS;
            end else if (!is_gap(c)) begin
               phase = jofe_pkg::PH_BAD;
            end
         end
         jofe_pkg::PH_SIGN: begin
            if (is_numeral(c)) begin
               add_numeral(c);
               phase = jofe_pkg::PH_DIGITS;
            end else begin
               phase = jofe_pkg::PH_BAD;
            end
         end
         jofe_pkg::PH_DIGITS: begin
            if (is_numeral(c)) add_numeral(c);
            else if (ends_number(c)) phase = jofe_pkg::PH_GOOD;
            else phase = jofe_pkg::PH_BAD;
         end
         default: ;
      endcase
   endtask

   function automatic offset_result_type predict_offset();
      offset_result_type r;
      int lo, hi, sec, q;
      r.ok = 1'b0;
      r.quarters = '0;
      lo = int'(lim_min);
      hi = int'(lim_max);
      if (!fail_hit && phase == jofe_pkg::PH_GOOD && int'(mag) < MAG_CEIL) begin
         sec = minus ? -int'(mag) : int'(mag);
         if (sec >= lo * SEC_PER_QUARTER && sec <= hi * SEC_PER_QUARTER) begin
            // halves go away from zero
            q = (int'(mag) + HALF_QUARTER) / SEC_PER_QUARTER;
            if (minus) q = -q;
            if (q >= lo && q <= hi) begin
               r.ok = 1'b1;
               r.quarters = 8'(q);
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      offset_result_type seen, want;
      if (reset) begin
         lim_min = -8'sd48;
         lim_max = 7'd56;
         clear_parse();
         expected_offsets.delete();
         mismatches = 0;
         compared = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == jofe_pkg::CSR_MIN_QUARTERS) lim_min = csr_wdata;
            else lim_max = csr_wdata[6:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.ok = rsp_tdata[0];
            seen.quarters = rsp_tdata[8:1];
            if (expected_offsets.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: result transfer with nothing pending: valid=%0d q=%0d",
                     $realtime, seen.ok, seen.quarters);
               end
               mismatches++;
            end else begin
               want = expected_offsets.pop_front();
               compared++;
               if (seen.ok !== want.ok || seen.quarters !== want.quarters) begin
                  if (mismatches < 10) begin
                     $display("%0t: offset result differs: expected valid=%0d q=%0d, got valid=%0d q=%0d",
                        $realtime, want.ok, want.quarters, seen.ok, seen.quarters);
                  end
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               expected_offsets.push_back(predict_offset());
               clear_parse();
            end else begin
               scan_char(req_tdata);
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count <= expected_offsets.size();
      compared_count <= compared;
   end

endmodule

FILE: sim/tb_json_offset_field_extractor.sv
// stimulus, clock, reset and verdict for the offset field extractor
`timescale 1ns / 1ps

module tb_json_offset_field_extractor;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEMS_PER_SETTING = 200;
   localparam int SETTING_COUNT = 9;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // char_code
   logic        req_tuser = 1'b0; // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // valid_res, quarter_hours[8:1], zeros
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [7:0]  csr_wdata = '0;

   int mismatch_total;
   int pending;
   int compared_total;

   int  items_sent = 0;
   int  settings_used = 1;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;

   logic [7:0] text_q[$];
   string noise_chars = "\"fail offset:{}+-,0123456789 \t\r\nx";
   string term_chars = ",} \r\n\t";

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   json_offset_field_extractor dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   offset_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatch_total),
      .pending_count (pending),
      .compared_count(compared_total)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d results pending", pending);
         $display("Mismatches found");
         $finish;
      end
   end

   // result side back-pressure: mostly short stalls, a few long ones
   always @(posedge clock) begin : rsp_stall
      int pick;
      logic ready_next;
      ready_next = 1'b1;
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (!calm) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            stall_left = $urandom_range(0, 3);
            ready_next = 1'b0;
         end else if (pick < 23) begin
            stall_left = $urandom_range(10, 40);
            ready_next = 1'b0;
         end
      end
      rsp_tready <= ready_next;
   end

   function automatic int gap_length();
      int pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_byte(input logic kind, input logic [7:0] ch);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= ch;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_string(input string s, input bit with_end);
      for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i]);
      if (with_end) send_byte(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(1'b0, text_q[i]);
      send_byte(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // limits change only once every result is back and the pipeline has drained
   task automatic apply_limits(input int lo, input int hi);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= jofe_pkg::CSR_MIN_QUARTERS;
      csr_wdata <= 8'(lo);
      @(posedge clock);
      csr_addr <= jofe_pkg::CSR_MAX_QUARTERS;
      csr_wdata <= 8'(hi);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic push_noise(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) text_q.push_back(8'($urandom_range(0, 255)));
         else text_q.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
      end
   endtask

   task automatic push_blanks();
      int n;
      n = $urandom_range(0, 2);
      repeat (n) push_str($urandom_range(0, 1) ? " " : "\t");
   endtask

   function automatic string number_text();
      int pick, q, off, mag;
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
         // values close to quarter-hour steps and their rounding halves
         q = $urandom_range(0, 130);
         off = $urandom_range(0, 900);
         case ($urandom_range(0, 4))
            0: mag = q * 900 + 450;
            1: mag = q * 900 - 450;
            2: mag = q * 900 + 449;
            3: mag = q * 900 - 449;
            default: mag = q * 900 + off - 450;
         endcase
         if (mag < 0) mag = 0;
         return $sformatf("%0d", mag);
      end
      if (pick == 7) return $sformatf("%0d", $urandom_range(0, 131070));
      if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return "131071";
            1: return "131070";
            2: return "131072";
            default: return "99999999";
         endcase
      end
      return $sformatf("00%0d", $urandom_range(0, 9));
   endfunction

   task automatic build_text();
      int pick;
      text_q.delete();
      pick = $urandom_range(0, 99);
      push_noise($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) push_str("\"fail\"");
      if (pick < 85) begin
         case ($urandom_range(0, 19))
            0: push_str("\"offse\"");
            1: push_str("\"\"offset\"");
            default: push_str("\"offset\"");
         endcase
         push_blanks();
         if ($urandom_range(0, 29) == 0) push_noise(1);
         else push_str(":");
         push_blanks();
         case ($urandom_range(0, 3))
            0, 1: push_str("-");
            2: push_str("+");
            default: ;
         endcase
         if ($urandom_range(0, 39) != 0) push_str(number_text());
         case ($urandom_range(0, 19))
            0: ;
            1: push_noise(1);
            default: text_q.push_back(term_chars[$urandom_range(0, term_chars.len() - 1)]);
         endcase
         push_noise($urandom_range(0, 3));
         if ($urandom_range(0, 7) == 0) push_str("\"offset\":5,");
         if ($urandom_range(0, 19) == 0) push_str("\"fail\"");
      end else begin
         push_noise($urandom_range(1, 12));
      end
   endtask

   initial begin : stimulus
      int target, lo, hi;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed texts under the reset limits
      send_string("\"offset\":-43200,", 1'b1);
      send_string("\"offset\" \t: +50400}", 1'b1);
      send_string("\"offset\":50401\r", 1'b1);
      send_string("\"offset\":-0\n", 1'b1);
      send_string("\"offset\":450\t", 1'b1);
      send_string("\"offset\":-449,", 1'b1);
      send_string("\"offset\":131071,", 1'b1);
      send_string("\"offset\":3600", 1'b1);
      send_string("\"\"offset\":7,\"offset\":9,", 1'b1);
      send_string("\"fai\"fail\"\"offset\":0,", 1'b1);
      send_string("\"offset\"x:1,", 1'b1);
      send_string("\"offset\":+,", 1'b1);
      // zero byte is no terminator, 0xff breaks the number
      send_string("\"offset\":9", 1'b0);
      send_byte(1'b0, 8'h00);
      send_byte(1'b1, 8'hFF);
      send_string("\"offset\":", 1'b0);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b1, 8'h00);
      send_byte(1'b1, 8'h00);
      // crossed limits and a positive minimum
      apply_limits(20, 10);
      send_string("\"offset\":13500,", 1'b1);
      apply_limits(8, 40);
      send_string("\"offset\":9000,", 1'b1);
      send_string("\"offset\":6749,", 1'b1);

      target = 0;
      for (int s = 0; s < SETTING_COUNT; s++) begin
         case (s)
            0: begin lo = -48; hi = 56; end
            1: begin lo = -128; hi = 127; end
            2: begin lo = 0; hi = 0; end
            3: begin lo = -128; hi = 0; end
            4: begin lo = 0; hi = 127; end
            5: begin lo = 20; hi = 10; end
            6: begin lo = 8; hi = 40; end
            default: begin
               lo = $urandom_range(0, 128);
               lo = -lo;
               hi = $urandom_range(0, 127);
            end
         endcase
         apply_limits(lo, hi);
         target += ITEMS_PER_SETTING;
         while (items_sent < target) begin
            calm = ($urandom_range(0, 9) == 0);
            build_text();
            send_text();
         end
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      $display("%0d transfers sent, %0d offset results compared across %0d limit settings",
         items_sent, compared_total, settings_used);
      if (mismatch_total == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
